@@ src/ttrq_pkg.sv @@
// ----------------------------------------------------------------------------
// ttrq_pkg
// Shared types and constants of the timed topic ring queue.
// ----------------------------------------------------------------------------
package ttrq_pkg;

   localparam int TOPIC_COUNT_DEF = 8;
   localparam int RING_DEPTH_DEF  = 16;

   localparam int CAP_W   = 5;
   localparam int LIMIT_W = 32;
   localparam int SEQ_W   = 32;
   localparam int STAMP_W = 48;
   localparam int HDL_W   = 16;

   localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1000000;

   localparam logic       CSR_CAPACITY  = 1'b0;
   localparam logic       CSR_AGE_LIMIT = 1'b1;

   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_CLEANUP = 2'd1;
   localparam logic [1:0] ACT_GET     = 2'd2;

   localparam logic [1:0] STAT_NONE  = 2'd0;
   localparam logic [1:0] STAT_DONE  = 2'd1;
   localparam logic [1:0] STAT_LATER = 2'd2;

   typedef struct packed {
      logic [SEQ_W-1:0]   number;
      logic [STAMP_W-1:0] stamp;
      logic [HDL_W-1:0]   publisher;
      logic [HDL_W-1:0]   url;
      logic [HDL_W-1:0]   caption;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

@@ src/timed_topic_ring_queue.sv @@
// ----------------------------------------------------------------------------
// timed_topic_ring_queue
// Per-topic bounded ring queues with sequence numbering and age expiry.
// ----------------------------------------------------------------------------
// One ring of RING_DEPTH slots per topic lives in a single slot RAM; head,
// tail, fill and sequence counters sit in flops. Enqueue stores its slot in
// the accept cycle and then goes to the done state. Cleanup and get walk the
// ring from the head, one slot per cycle through the RAM read port and one
// shared compare unit. Cleanup stops at the first entry that has not aged or
// when the ring is empty. A finished result waits in the output register
// while the next transaction is accepted. No clearing pass is needed after
// reset; data read from unwritten slots is never used.
// ----------------------------------------------------------------------------
module timed_topic_ring_queue #(
   parameter int TOPIC_COUNT = ttrq_pkg::TOPIC_COUNT_DEF,
   parameter int RING_DEPTH  = ttrq_pkg::RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_topic,
   input  logic [15:0] req_publisher,
   input  logic [15:0] req_url_ref,
   input  logic [15:0] req_caption_ref,
   input  logic [31:0] req_last_seen,
   input  logic [47:0] req_now_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_removed_count,
   output logic [31:0] rsp_entry_number,
   output logic [15:0] rsp_entry_publisher,
   output logic [15:0] rsp_entry_url,
   output logic [15:0] rsp_entry_caption,
   output logic [47:0] rsp_entry_stamp
);

   import ttrq_pkg::*;

   localparam int TW = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;
   localparam int PW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam int AW = $clog2(TOPIC_COUNT * RING_DEPTH);

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] slot_addr(input logic [TW-1:0] t,
                                                input logic [PW-1:0] p);
      return AW'(t) * AW'(RING_DEPTH) + AW'(p);
   endfunction

   // configuration
   logic [CAP_W-1:0]   cap_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // per-topic ring state
   logic [PW-1:0]    head_ff [TOPIC_COUNT];
   logic [PW-1:0]    tail_ff [TOPIC_COUNT];
   logic [FW-1:0]    fill_ff [TOPIC_COUNT];
   logic [SEQ_W-1:0] seq_ff  [TOPIC_COUNT];

   // transaction working registers
   state_type          state_ff, state_in;
   logic [1:0]         act_ff;
   logic [TW-1:0]      topic_ff;
   logic [SEQ_W-1:0]   target_ff;
   logic [STAMP_W-1:0] now_ff;
   logic [PW-1:0]      rd_ptr_ff;
   logic [FW-1:0]      cnt_ff;
   logic               dv_ff;
   logic               cand_ff;
   logic [1:0]         res_status_ff;
   logic [4:0]         res_removed_ff;
   slot_type           res_entry_ff;

   // output register
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [4:0]         rsp_removed_ff;
   slot_type           rsp_entry_ff;

   logic          accept;
   logic [TW-1:0] req_t;
   logic          topic_ok;
   logic [FW-1:0] req_fill;
   logic [8:0]    cap_eff;
   logic          enq_ok;
   logic          go_scan;
   logic          rd_en;
   logic          load_rsp;
   slot_type      wr_slot;
   slot_type      rd_slot;
   logic          chk;
   logic          aged;
   logic          hit_eq;
   logic          hit_gt;
   logic          scan_end;

   assign req_t    = TW'(req_topic);
   assign topic_ok = 32'(req_topic) < 32'(TOPIC_COUNT);
   assign req_fill = fill_ff[req_t];
   // capacity above the ring depth acts as the ring depth
   assign cap_eff  = (9'(cap_ff) > 9'(RING_DEPTH)) ? 9'(RING_DEPTH) : 9'(cap_ff);
   assign accept   = req_valid && !req_stall;
   assign enq_ok   = accept && topic_ok && (req_action == ACT_ENQUEUE)
                     && (9'(req_fill) < cap_eff);
   assign go_scan  = accept && topic_ok && (req_fill != '0)
                     && ((req_action == ACT_CLEANUP) || (req_action == ACT_GET));

   assign wr_slot = '{number: seq_ff[req_t] + 1'b1, stamp: req_now_us,
                      publisher: req_publisher, url: req_url_ref,
                      caption: req_caption_ref};

   ttrq_ram #(
      .WIDTH($bits(slot_type)),
      .DEPTH(TOPIC_COUNT * RING_DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (enq_ok),
      .wr_addr(slot_addr(req_t, tail_ff[req_t])),
      .wr_data(wr_slot),
      .rd_en  (rd_en),
      .rd_addr(slot_addr(topic_ff, rd_ptr_ff)),
      .rd_data(rd_slot)
   );

   // shared compare unit: age check for cleanup, number match for get
   assign chk    = (state_ff == ST_SCAN) && dv_ff;
   assign aged   = (now_ff >= rd_slot.stamp)
                   && ((now_ff - rd_slot.stamp) >= STAMP_W'(limit_ff));
   assign hit_eq = rd_slot.number == target_ff;
   assign hit_gt = rd_slot.number > target_ff;

   always_comb begin
      scan_end = 1'b0;
      if (chk) begin
         if (act_ff == ACT_CLEANUP) begin
            scan_end = !aged || (fill_ff[topic_ff] == FW'(1));
         end else begin
            scan_end = hit_eq || (cnt_ff == FW'(1));
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go_scan) begin
               state_in = ST_SCAN;
            end else if (accept) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_SCAN: rd_en = 1'b1;
         ST_DONE: load_rsp = !rsp_valid_ff || !rsp_stall;
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
         limit_ff     <= LIMIT_RESET;
         dv_ff        <= 1'b0;
         for (int i = 0; i < TOPIC_COUNT; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
            seq_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         dv_ff    <= (state_ff == ST_SCAN);

         if (csr_we) begin
            if (csr_index == CSR_CAPACITY) begin
               cap_ff <= csr_wdata[CAP_W-1:0];
            end else begin
               limit_ff <= csr_wdata;
            end
         end

         // enqueue: store and advance tail in the accept cycle
         if (enq_ok) begin
            tail_ff[req_t] <= next_ptr(tail_ff[req_t]);
            fill_ff[req_t] <= req_fill + 1'b1;
            seq_ff[req_t]  <= seq_ff[req_t] + 1'b1;
         end

         // cleanup: pop the aged head
         if (chk && (act_ff == ACT_CLEANUP) && aged) begin
            head_ff[topic_ff] <= next_ptr(head_ff[topic_ff]);
            fill_ff[topic_ff] <= fill_ff[topic_ff] - 1'b1;
         end

         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff         <= req_action;
         topic_ff       <= req_t;
         target_ff      <= req_last_seen + 1'b1;
         now_ff         <= req_now_us;
         rd_ptr_ff      <= head_ff[req_t];
         cnt_ff         <= req_fill;
         cand_ff        <= 1'b0;
         res_removed_ff <= '0;
         res_entry_ff   <= enq_ok ? wr_slot : '0;
         res_status_ff  <= (enq_ok || (go_scan && (req_action == ACT_CLEANUP)))
                           ? STAT_DONE : STAT_NONE;
      end
      if (state_ff == ST_SCAN) begin
         rd_ptr_ff <= next_ptr(rd_ptr_ff);
      end
      if (chk) begin
         if (act_ff == ACT_CLEANUP) begin
            if (aged) begin
               res_entry_ff   <= rd_slot;
               res_removed_ff <= res_removed_ff + 1'b1;
            end
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
            if (hit_eq) begin
               res_entry_ff  <= rd_slot;
               res_status_ff <= STAT_DONE;
            end else if (hit_gt && !cand_ff) begin
               // keep the first later entry in ring order
               res_entry_ff  <= rd_slot;
               res_status_ff <= STAT_LATER;
               cand_ff       <= 1'b1;
            end
         end
      end
      if (load_rsp) begin
         rsp_status_ff  <= res_status_ff;
         rsp_removed_ff <= res_removed_ff;
         rsp_entry_ff   <= res_entry_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_removed_count   = rsp_removed_ff;
   assign rsp_entry_number    = rsp_entry_ff.number;
   assign rsp_entry_publisher = rsp_entry_ff.publisher;
   assign rsp_entry_url       = rsp_entry_ff.url;
   assign rsp_entry_caption   = rsp_entry_ff.caption;
   assign rsp_entry_stamp     = rsp_entry_ff.stamp;

endmodule

@@ src/ttrq_ram.sv @@
// ----------------------------------------------------------------------------
// ttrq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ttrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed topic ring queue.
// ----------------------------------------------------------------------------
// Drives enqueue, cleanup, get and unused actions with random idle bursts on
// both sides. A scoreboard class keeps its own copy of the per-topic rings and
// compares every result, field by field, with the predicted transaction.
// ----------------------------------------------------------------------------
module tb_top;
   import ttrq_pkg::*;

   localparam int NTOPIC = 8;
   localparam int DEPTH  = 16;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  removed;
      logic [31:0] number;
      logic [15:0] publisher;
      logic [15:0] url;
      logic [15:0] caption;
      logic [47:0] stamp;
   } queue_result_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  topic;
      logic [15:0] publisher;
      logic [15:0] url;
      logic [15:0] caption;
      logic [31:0] last_seen;
      logic [47:0] now_us;
   } queue_request_type;

   // Predictor of the ring queues plus the list of pending results.
   class ring_scoreboard;
      logic [4:0]  capacity;
      logic [31:0] age_limit;
      logic [3:0]  head [NTOPIC];
      logic [3:0]  tail [NTOPIC];
      logic [4:0]  fill [NTOPIC];
      logic [31:0] seq  [NTOPIC];
      logic [31:0] s_num [NTOPIC*DEPTH];
      logic [47:0] s_stamp [NTOPIC*DEPTH];
      logic [15:0] s_pub [NTOPIC*DEPTH];
      logic [15:0] s_url [NTOPIC*DEPTH];
      logic [15:0] s_cap [NTOPIC*DEPTH];
      queue_result_type pending [$];
      int errors;
      int checked;

      function new();
         capacity = CAP_RESET;
         age_limit = LIMIT_RESET;
         errors = 0;
         checked = 0;
         for (int t = 0; t < NTOPIC; t++) begin
            head[t] = 0; tail[t] = 0; fill[t] = 0; seq[t] = 0;
         end
      endfunction

      function void set_reg(logic idx, logic [31:0] val);
         if (idx == CSR_CAPACITY) capacity = val[4:0];
         else age_limit = val;
      endfunction

      function int topic_fill(int t);
         return fill[t];
      endfunction

      function void load_entry(ref queue_result_type r, input int s);
         r.number = s_num[s];
         r.publisher = s_pub[s];
         r.url = s_url[s];
         r.caption = s_cap[s];
         r.stamp = s_stamp[s];
      endfunction

      // Note an accepted request and queue its expected result.
      function void note_request(queue_request_type q);
         queue_result_type r;
         int base, s, cap, p;
         logic [31:0] target;
         bit found;
         r = '0;
         base = q.topic * DEPTH;
         found = 0;
         case (q.action)
            ACT_ENQUEUE: begin
               cap = (capacity > DEPTH) ? DEPTH : capacity;
               if (fill[q.topic] < cap) begin
                  s = base + tail[q.topic];
                  seq[q.topic] = seq[q.topic] + 32'd1;
                  s_num[s] = seq[q.topic];
                  s_stamp[s] = q.now_us;
                  s_pub[s] = q.publisher;
                  s_url[s] = q.url;
                  s_cap[s] = q.caption;
                  tail[q.topic] = tail[q.topic] + 4'd1;
                  fill[q.topic] = fill[q.topic] + 5'd1;
                  r.status = STAT_DONE;
                  load_entry(r, s);
               end
            end
            ACT_CLEANUP: begin
               if (fill[q.topic] != 0) begin
                  r.status = STAT_DONE;
                  while (fill[q.topic] != 0) begin
                     s = base + head[q.topic];
                     if (q.now_us < s_stamp[s]) break;
                     if ((q.now_us - s_stamp[s]) < {16'd0, age_limit}) break;
                     load_entry(r, s);
                     head[q.topic] = head[q.topic] + 4'd1;
                     fill[q.topic] = fill[q.topic] - 5'd1;
                     r.removed = r.removed + 5'd1;
                  end
               end
            end
            ACT_GET: begin
               target = q.last_seen + 32'd1;
               p = head[q.topic];
               for (int i = 0; i < fill[q.topic] && !found; i++) begin
                  if (s_num[base + p] == target) begin
                     r.status = STAT_DONE; load_entry(r, base + p); found = 1;
                  end
                  p = (p + 1) % DEPTH;
               end
               p = head[q.topic];
               for (int i = 0; i < fill[q.topic] && !found; i++) begin
                  if (s_num[base + p] > target) begin
                     r.status = STAT_LATER; load_entry(r, base + p); found = 1;
                  end
                  p = (p + 1) % DEPTH;
               end
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function void check_result(queue_result_type got);
         queue_result_type want;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.removed !== want.removed) begin
            $display("%0t: removed exp %0d got %0d", $time, want.removed, got.removed);
            errors++;
         end
         if (got.number !== want.number) begin
            $display("%0t: number exp %h got %h", $time, want.number, got.number);
            errors++;
         end
         if (got.publisher !== want.publisher) begin
            $display("%0t: publisher exp %h got %h", $time, want.publisher,
                     got.publisher);
            errors++;
         end
         if (got.url !== want.url) begin
            $display("%0t: url exp %h got %h", $time, want.url, got.url);
            errors++;
         end
         if (got.caption !== want.caption) begin
            $display("%0t: caption exp %h got %h", $time, want.caption, got.caption);
            errors++;
         end
         if (got.stamp !== want.stamp) begin
            $display("%0t: stamp exp %h got %h", $time, want.stamp, got.stamp);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [2:0]  req_topic;
   logic [15:0] req_publisher;
   logic [15:0] req_url_ref;
   logic [15:0] req_caption_ref;
   logic [31:0] req_last_seen;
   logic [47:0] req_now_us;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_removed_count;
   logic [31:0] rsp_entry_number;
   logic [15:0] rsp_entry_publisher;
   logic [15:0] rsp_entry_url;
   logic [15:0] rsp_entry_caption;
   logic [47:0] rsp_entry_stamp;

   timed_topic_ring_queue u_top (.*);

   ring_scoreboard board;
   logic [47:0] clock_us;       // running time base handed to the block
   bit          quiet_tail;     // no idling in the last part of the run
   bit          hold_rsp;       // request a long receiver hold-off
   int          cycle_count;
   int          sent;
   int          seen_status [3];

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Watchdog on total cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // Sample results at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result({rsp_status, rsp_removed_count, rsp_entry_number,
                             rsp_entry_publisher, rsp_entry_url, rsp_entry_caption,
                             rsp_entry_stamp});
         if (rsp_status < 3) seen_status[rsp_status]++;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int n;
      rsp_stall = 1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
         end else begin
            rsp_stall <= 0;
            @(negedge clock);
         end
      end
   end

   task automatic write_reg(logic idx, logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      board.set_reg(idx, val);
   endtask

   // Drop the request, wait until every expected result has arrived, then
   // let the block settle.
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Offer one transaction; hold it until accepted. Valid stays high after
   // the accept so that the next transaction can follow back to back.
   task automatic send(queue_request_type q);
      int n;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 8);
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1;
      {req_action, req_topic, req_publisher, req_url_ref, req_caption_ref,
       req_last_seen, req_now_us} <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(q);
      sent++;
      @(negedge clock);
   endtask

   function automatic queue_request_type make_req(logic [1:0] act, logic [2:0] t,
                                                  logic [31:0] seen,
                                                  logic [47:0] now);
      queue_request_type q;
      q.action = act;
      q.topic = t;
      q.publisher = 16'($urandom);
      q.url = 16'($urandom);
      q.caption = 16'($urandom);
      q.last_seen = seen;
      q.now_us = now;
      return q;
   endfunction

   // Random mix on low topics, unused action too, time mostly moving forward.
   task automatic random_phase(int count, int topics);
      queue_request_type q;
      int r;
      logic [31:0] seen;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         clock_us = clock_us + 48'($urandom_range(0, 400));
         if (r < 3) clock_us = clock_us - 48'($urandom_range(0, 2000));
         q = make_req(r < 50 ? ACT_ENQUEUE : (r < 70 ? ACT_CLEANUP : ACT_GET),
                      3'($urandom_range(0, topics - 1)), 0, clock_us);
         if (r >= 97) q.action = 2'd3;
         seen = board.seq[q.topic] - $urandom_range(0, 18);
         if ($urandom_range(0, 9) == 0) seen = $urandom;
         q.last_seen = seen;
         if ($urandom_range(0, 30) == 0) q.now_us = 48'({$urandom, $urandom});
         send(q);
      end
   endtask

   initial begin
      queue_request_type q;
      board = new();
      reset = 1;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      req_valid = 0;
      {req_action, req_topic, req_publisher, req_url_ref, req_caption_ref,
       req_last_seen, req_now_us} = '0;
      quiet_tail = 0; hold_rsp = 0; cycle_count = 0; sent = 0;
      clock_us = 48'd5000;
      repeat (10) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // Directed: reset settings, empty queues, extremes of the fields.
      send(make_req(ACT_CLEANUP, 0, 0, 0));
      send(make_req(ACT_GET, 7, 32'hffffffff, 48'hffffffffffff));
      q = make_req(ACT_ENQUEUE, 0, 0, 48'hffffffffffff);
      q.publisher = 16'hffff; q.url = 16'hffff; q.caption = 16'hffff;
      send(q);
      q = make_req(ACT_ENQUEUE, 0, 0, 0);
      q.publisher = 0; q.url = 0; q.caption = 0;
      send(q);
      send(make_req(ACT_ENQUEUE, 7, 0, 48'd100));
      send(make_req(ACT_GET, 0, 0, 0));              // exact match
      send(make_req(ACT_GET, 0, 32'hffffffff, 0));   // target wraps to 0: later
      send(make_req(ACT_GET, 0, 5, 0));              // nothing newer
      send(make_req(2'd3, 2, 0, 0));                 // unused action
      send(make_req(ACT_CLEANUP, 0, 0, 48'd10));     // head stamped in future
      send(make_req(ACT_CLEANUP, 7, 0, 48'd1000100)); // exactly at limit
      drain();
      // Zero capacity and zero age limit.
      write_reg(CSR_CAPACITY, 0);
      write_reg(CSR_AGE_LIMIT, 0);
      send(make_req(ACT_ENQUEUE, 1, 0, 0));
      send(make_req(ACT_CLEANUP, 0, 0, 48'hffffffffffff));
      drain();
      // Capacity above depth is capped; fill topic 3 to the brim.
      write_reg(CSR_CAPACITY, 31);
      write_reg(CSR_AGE_LIMIT, 32'hffffffff);
      for (int i = 0; i < 17; i++) send(make_req(ACT_ENQUEUE, 3, 0, 48'(i)));
      send(make_req(ACT_GET, 3, 10, 0));
      // Capacity lowered below fill keeps entries.
      drain();
      write_reg(CSR_CAPACITY, 1);
      send(make_req(ACT_ENQUEUE, 3, 0, 0));
      send(make_req(ACT_CLEANUP, 3, 0, 48'hffffffffffff));
      drain();

      // Random phases across several register settings.
      write_reg(CSR_CAPACITY, 4);
      write_reg(CSR_AGE_LIMIT, 1500);
      random_phase(150, 3);
      drain();
      write_reg(CSR_CAPACITY, 16);
      write_reg(CSR_AGE_LIMIT, 6000);
      random_phase(150, 8);
      // Long receiver hold-off while requests keep coming.
      drain();
      hold_rsp = 1;
      random_phase(60, 2);
      drain();
      write_reg(CSR_CAPACITY, 9);
      write_reg(CSR_AGE_LIMIT, 800);
      quiet_tail = 1;
      random_phase(200, 4);

      drain();
      $display("sent %0d transactions; results none/done/later: %0d/%0d/%0d",
               sent, seen_status[0], seen_status[1], seen_status[2]);
      if (board.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/ttrq_pkg.sv
src/ttrq_ram.sv
src/timed_topic_ring_queue.sv
bench/tb_top.sv
